// ----- design/ffha_pkg.sv -----
// Package for the first-fit heap allocator: granule store geometry, block word
// positions, command and status codes, register indexes and hash multipliers.
// It depends on nothing.
package ffha_pkg;

   localparam int ARENA_GRANULES = 262144;
   localparam int GRANULE_BYTES  = 16;
   localparam int SLOT_W         = $clog2(ARENA_GRANULES);
   localparam int STEP_W         = $clog2(ARENA_GRANULES + 1);
   localparam int WORD_W         = 32;
   localparam int CFG_W          = 23;
   localparam int SIZE_W         = 24;
   localparam int ADDR_W         = 22;

   localparam logic [WORD_W-1:0] ALLOC_MUL = 32'd2654435761;
   localparam logic [WORD_W-1:0] FREE_MUL  = 32'd265435761;
   localparam logic [WORD_W-1:0] GRAN_B    = 32'd16;

   localparam logic [1:0] W_SIZE = 2'd0;
   localparam logic [1:0] W_PREV = 2'd1;
   localparam logic [1:0] W_NEXT = 2'd2;
   localparam logic [1:0] W_SANE = 2'd3;

   localparam logic [1:0] CMD_INIT   = 2'd0;
   localparam logic [1:0] CMD_ALLOC  = 2'd1;
   localparam logic [1:0] CMD_FREE   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_SIZE = 2'd1;
   localparam logic [1:0] ST_NO_MEM   = 2'd2;
   localparam logic [1:0] ST_SANITY   = 2'd3;

   localparam logic [1:0] REG_ARENA_START = 2'd0;
   localparam logic [1:0] REG_HOLE_START  = 2'd1;
   localparam logic [1:0] REG_HOLE_END    = 2'd2;
   localparam logic [1:0] REG_ARENA_END   = 2'd3;

   localparam logic [CFG_W-1:0] RST_ARENA_START = 23'd4096;
   localparam logic [CFG_W-1:0] RST_HOLE_START  = 23'd655360;
   localparam logic [CFG_W-1:0] RST_HOLE_END    = 23'd1048576;
   localparam logic [CFG_W-1:0] RST_ARENA_END   = 23'd4194304;

   function automatic logic [SLOT_W-1:0] slot_f(input logic [WORD_W-1:0] a);
      return a[SLOT_W+3:4];
   endfunction

endpackage

// ----- design/first_fit_heap_allocator.sv -----
// First-fit heap allocator with boundary-tag coalescing over a granule memory.
// Depends on ffha_pkg for geometry, codes and hash multipliers.
// An alloc walks the free list from its head until a block fits or the list ends; a free
// ends early with a sanity status when the hash check of the block header fails.
// One item at a time; a new request is taken once the result is in the output register.
// Reset clears the list head and restores the registers, then a pass zeroes all of memory.
module first_fit_heap_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_command,
   input  logic signed [ffha_pkg::SIZE_W-1:0] req_request_size,
   input  logic [ffha_pkg::ADDR_W-1:0]   req_release_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ffha_pkg::ADDR_W-1:0]   rsp_data_address,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [ffha_pkg::CFG_W-1:0]    csr_wdata
);

   localparam int SW = 6;
   localparam logic [SW-1:0] S_IDLE   = 6'd0;
   localparam logic [SW-1:0] S_DONE   = 6'd1;
   localparam logic [SW-1:0] S_PF_RD  = 6'd2;
   localparam logic [SW-1:0] S_PF_W0  = 6'd3;
   localparam logic [SW-1:0] S_PF_W3  = 6'd4;
   localparam logic [SW-1:0] S_M_RD   = 6'd5;
   localparam logic [SW-1:0] S_M_LNK  = 6'd6;
   localparam logic [SW-1:0] S_M_P    = 6'd7;
   localparam logic [SW-1:0] S_M_N    = 6'd8;
   localparam logic [SW-1:0] S_M_RDF  = 6'd9;
   localparam logic [SW-1:0] S_M_RDS  = 6'd10;
   localparam logic [SW-1:0] S_M_SUM  = 6'd11;
   localparam logic [SW-1:0] S_M_HS   = 6'd12;
   localparam logic [SW-1:0] S_I_S0   = 6'd13;
   localparam logic [SW-1:0] S_I_H0   = 6'd14;
   localparam logic [SW-1:0] S_I_S1   = 6'd15;
   localparam logic [SW-1:0] S_I_H1   = 6'd16;
   localparam logic [SW-1:0] S_I_L0   = 6'd17;
   localparam logic [SW-1:0] S_I_L1   = 6'd18;
   localparam logic [SW-1:0] S_I_L2   = 6'd19;
   localparam logic [SW-1:0] S_I_L3   = 6'd20;
   localparam logic [SW-1:0] S_AW_CHK = 6'd21;
   localparam logic [SW-1:0] S_AF_SZ  = 6'd22;
   localparam logic [SW-1:0] S_AF_HS  = 6'd23;
   localparam logic [SW-1:0] S_AF_RD1 = 6'd24;
   localparam logic [SW-1:0] S_AF_P   = 6'd25;
   localparam logic [SW-1:0] S_AF_PL  = 6'd26;
   localparam logic [SW-1:0] S_AF_RD2 = 6'd27;
   localparam logic [SW-1:0] S_AF_N   = 6'd28;
   localparam logic [SW-1:0] S_AF_NL  = 6'd29;
   localparam logic [SW-1:0] S_AF_HDR = 6'd30;
   localparam logic [SW-1:0] S_AF_ST  = 6'd31;
   localparam logic [SW-1:0] S_F_CHK  = 6'd32;
   localparam logic [SW-1:0] S_F_C1   = 6'd33;
   localparam logic [SW-1:0] S_F_C2   = 6'd34;
   localparam logic [SW-1:0] S_F_RD1  = 6'd35;
   localparam logic [SW-1:0] S_F_AFT  = 6'd36;
   localparam logic [SW-1:0] S_F_CHKA = 6'd37;
   localparam logic [SW-1:0] S_F_RDP  = 6'd38;
   localparam logic [SW-1:0] S_F_CHKP = 6'd39;
   localparam logic [SW-1:0] S_F_P1   = 6'd40;
   localparam logic [SW-1:0] S_F_P2   = 6'd41;
   localparam logic [SW-1:0] S_F_P3   = 6'd42;
   localparam logic [SW-1:0] S_F_RD2  = 6'd43;
   localparam logic [SW-1:0] S_F_ST   = 6'd44;

   localparam int WW = ffha_pkg::WORD_W;
   localparam int LW = ffha_pkg::SLOT_W;

   logic [4*WW-1:0] granule_mem_ff [ffha_pkg::ARENA_GRANULES];
   logic [4*WW-1:0] mem_rdata_ff;

   logic [SW-1:0] state_ff, state_in, ret_ff, ret_in;
   logic [WW-1:0] cur_ff, cur_in, aux_ff, aux_in, sz_ff, sz_in;
   logic [WW-1:0] lnk_p_ff, lnk_p_in, lnk_n_ff, lnk_n_in;
   logic [WW-1:0] m_first_ff, m_first_in, m_second_ff, m_second_in;
   logic [WW-1:0] pf_hdr_ff, pf_hdr_in, pf_ft_ff, pf_ft_in, pf_sz_ff, pf_sz_in;
   logic [WW-1:0] tmp_ff, tmp_in, amnt_ff, amnt_in, ptr_ff, ptr_in, head_ff, head_in;
   logic [ffha_pkg::STEP_W-1:0] steps_ff, steps_in;
   logic [1:0] stat_ff, stat_in;
   logic [ffha_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [ffha_pkg::CFG_W-1:0] arena_start_ff, hole_start_ff, hole_end_ff, arena_end_ff;
   logic clearing_ff, clearing_in;
   logic [LW-1:0] clr_idx_ff, clr_idx_in;

   logic rd_en, wr_en, h_alloc, accept;
   logic [WW-1:0] rd_addr, wr_addr, wr_data, h_addr, h_size, h_out, h_mul;
   logic [1:0] wr_word;
   logic [WW-1:0] rw0, rw1, rw2, rw3, start_w, amnt_w;

   assign rw0 = mem_rdata_ff[0*WW +: WW];
   assign rw1 = mem_rdata_ff[1*WW +: WW];
   assign rw2 = mem_rdata_ff[2*WW +: WW];
   assign rw3 = mem_rdata_ff[3*WW +: WW];

   assign h_mul = h_alloc ? ffha_pkg::ALLOC_MUL : ffha_pkg::FREE_MUL;
   assign h_out = WW'(h_addr * h_mul) + h_size;

   assign start_w = (WW'(arena_start_ff) + 32'd15) & ~32'd15;
   assign amnt_w  = ((WW'(req_request_size[ffha_pkg::SIZE_W-2:0]) + 32'd15) & ~32'd15)
                    + ffha_pkg::GRAN_B;

   assign req_stall = (state_ff != S_IDLE) || clearing_ff;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_address = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

   always_comb begin
      state_in = state_ff;     ret_in = ret_ff;
      cur_in = cur_ff;         aux_in = aux_ff;         sz_in = sz_ff;
      lnk_p_in = lnk_p_ff;     lnk_n_in = lnk_n_ff;
      m_first_in = m_first_ff; m_second_in = m_second_ff;
      pf_hdr_in = pf_hdr_ff;   pf_ft_in = pf_ft_ff;     pf_sz_in = pf_sz_ff;
      tmp_in = tmp_ff;         amnt_in = amnt_ff;       ptr_in = ptr_ff;
      head_in = head_ff;       steps_in = steps_ff;
      stat_in = stat_ff;       addr_in = addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_addr_in = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      clearing_in = clearing_ff;
      clr_idx_in = clr_idx_ff;
      rd_en = 1'b0;   rd_addr = '0;
      wr_en = 1'b0;   wr_addr = '0;  wr_word = ffha_pkg::W_SIZE;  wr_data = '0;
      h_alloc = 1'b0; h_addr = '0;   h_size = '0;

      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == LW'(ffha_pkg::ARENA_GRANULES - 1)) begin
            clearing_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               stat_in = ffha_pkg::ST_OK;
               addr_in = '0;
               ret_in  = S_DONE;
               case (req_command)
                  ffha_pkg::CMD_INIT: begin
                     head_in  = start_w;
                     cur_in   = start_w;
                     aux_in   = WW'(hole_end_ff);
                     state_in = S_I_S0;
                  end
                  ffha_pkg::CMD_ALLOC: begin
                     amnt_in  = amnt_w;
                     steps_in = '0;
                     cur_in   = head_ff;
                     if (req_request_size[ffha_pkg::SIZE_W-1] || req_request_size == '0) begin
                        stat_in  = ffha_pkg::ST_BAD_SIZE;
                        state_in = S_DONE;
                     end else if (head_ff == '0) begin
                        stat_in  = ffha_pkg::ST_NO_MEM;
                        state_in = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = S_AW_CHK;
                     end
                  end
                  ffha_pkg::CMD_FREE: begin
                     ptr_in   = WW'(req_release_address);
                     cur_in   = WW'(req_release_address) - ffha_pkg::GRAN_B;
                     rd_en    = 1'b1;
                     rd_addr  = WW'(req_release_address) - ffha_pkg::GRAN_B;
                     state_in = S_F_CHK;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = (stat_ff == ffha_pkg::ST_OK) ? addr_ff : '0;
               rsp_status_in = stat_ff;
               state_in      = S_IDLE;
            end
         end
         S_PF_RD: begin
            rd_en = 1'b1; rd_addr = pf_hdr_ff; state_in = S_PF_W0;
         end
         S_PF_W0: begin
            pf_sz_in = rw0;
            pf_ft_in = pf_hdr_ff + rw0;
            wr_en = 1'b1; wr_addr = pf_hdr_ff + rw0; wr_word = ffha_pkg::W_SIZE; wr_data = rw0;
            state_in = S_PF_W3;
         end
         S_PF_W3: begin
            h_addr = pf_ft_ff; h_size = pf_sz_ff;
            wr_en = 1'b1; wr_addr = pf_ft_ff; wr_word = ffha_pkg::W_SANE; wr_data = h_out;
            state_in = ret_ff;
         end
         S_M_RD: begin
            rd_en = 1'b1; rd_addr = m_second_ff; state_in = S_M_LNK;
         end
         S_M_LNK: begin
            lnk_p_in = rw1; lnk_n_in = rw2; state_in = S_M_P;
         end
         S_M_P: begin
            if (lnk_p_ff != '0) begin
               wr_en = 1'b1; wr_addr = lnk_p_ff; wr_word = ffha_pkg::W_NEXT; wr_data = lnk_n_ff;
            end else if (m_second_ff == head_ff) begin
               head_in = lnk_n_ff;
            end
            state_in = S_M_N;
         end
         S_M_N: begin
            if (lnk_n_ff != '0) begin
               wr_en = 1'b1; wr_addr = lnk_n_ff; wr_word = ffha_pkg::W_PREV; wr_data = lnk_p_ff;
            end
            state_in = S_M_RDF;
         end
         S_M_RDF: begin
            rd_en = 1'b1; rd_addr = m_first_ff; state_in = S_M_RDS;
         end
         S_M_RDS: begin
            tmp_in = rw0;
            rd_en = 1'b1; rd_addr = m_second_ff; state_in = S_M_SUM;
         end
         S_M_SUM: begin
            sz_in = tmp_ff + rw0 + ffha_pkg::GRAN_B;
            wr_en = 1'b1; wr_addr = m_first_ff; wr_word = ffha_pkg::W_SIZE;
            wr_data = tmp_ff + rw0 + ffha_pkg::GRAN_B;
            state_in = S_M_HS;
         end
         S_M_HS: begin
            h_addr = m_first_ff; h_size = sz_ff;
            wr_en = 1'b1; wr_addr = m_first_ff; wr_word = ffha_pkg::W_SANE; wr_data = h_out;
            pf_hdr_in = m_first_ff;
            state_in = S_PF_RD;
         end
         S_I_S0: begin
            sz_in = WW'(hole_start_ff) - cur_ff - ffha_pkg::GRAN_B;
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_SIZE;
            wr_data = WW'(hole_start_ff) - cur_ff - ffha_pkg::GRAN_B;
            state_in = S_I_H0;
         end
         S_I_H0: begin
            h_addr = cur_ff; h_size = sz_ff;
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_SANE; wr_data = h_out;
            pf_hdr_in = cur_ff; ret_in = S_I_S1; state_in = S_PF_RD;
         end
         S_I_S1: begin
            sz_in = WW'(arena_end_ff) - aux_ff - ffha_pkg::GRAN_B;
            wr_en = 1'b1; wr_addr = aux_ff; wr_word = ffha_pkg::W_SIZE;
            wr_data = WW'(arena_end_ff) - aux_ff - ffha_pkg::GRAN_B;
            state_in = S_I_H1;
         end
         S_I_H1: begin
            h_addr = aux_ff; h_size = sz_ff;
            wr_en = 1'b1; wr_addr = aux_ff; wr_word = ffha_pkg::W_SANE; wr_data = h_out;
            pf_hdr_in = aux_ff; ret_in = S_I_L0; state_in = S_PF_RD;
         end
         S_I_L0: begin
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_NEXT; wr_data = aux_ff;
            state_in = S_I_L1;
         end
         S_I_L1: begin
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_PREV; wr_data = '0;
            state_in = S_I_L2;
         end
         S_I_L2: begin
            wr_en = 1'b1; wr_addr = aux_ff; wr_word = ffha_pkg::W_NEXT; wr_data = '0;
            state_in = S_I_L3;
         end
         S_I_L3: begin
            wr_en = 1'b1; wr_addr = aux_ff; wr_word = ffha_pkg::W_PREV; wr_data = cur_ff;
            state_in = S_DONE;
         end
         S_AW_CHK: begin
            if (rw0 >= amnt_ff) begin
               aux_in = cur_ff + amnt_ff;
               sz_in  = rw0 - amnt_ff;
               state_in = S_AF_SZ;
            end else if (rw2 == '0 || steps_ff >= ffha_pkg::STEP_W'(ffha_pkg::ARENA_GRANULES)) begin
               stat_in  = ffha_pkg::ST_NO_MEM;
               state_in = S_DONE;
            end else begin
               steps_in = steps_ff + 1'b1;
               cur_in   = rw2;
               rd_en    = 1'b1;
               rd_addr  = rw2;
            end
         end
         S_AF_SZ: begin
            wr_en = 1'b1; wr_addr = aux_ff; wr_word = ffha_pkg::W_SIZE; wr_data = sz_ff;
            state_in = S_AF_HS;
         end
         S_AF_HS: begin
            h_addr = aux_ff; h_size = sz_ff;
            wr_en = 1'b1; wr_addr = aux_ff; wr_word = ffha_pkg::W_SANE; wr_data = h_out;
            if (sz_ff >= ffha_pkg::GRAN_B) begin
               pf_hdr_in = aux_ff; ret_in = S_AF_RD1; state_in = S_PF_RD;
            end else begin
               state_in = S_AF_RD1;
            end
         end
         S_AF_RD1: begin
            rd_en = 1'b1; rd_addr = cur_ff; state_in = S_AF_P;
         end
         S_AF_P: begin
            lnk_p_in = rw1;
            wr_en = 1'b1; wr_addr = aux_ff; wr_word = ffha_pkg::W_PREV; wr_data = rw1;
            state_in = S_AF_PL;
         end
         S_AF_PL: begin
            if (lnk_p_ff != '0) begin
               wr_en = 1'b1; wr_addr = lnk_p_ff; wr_word = ffha_pkg::W_NEXT; wr_data = aux_ff;
            end else begin
               head_in = aux_ff;
            end
            state_in = S_AF_RD2;
         end
         S_AF_RD2: begin
            rd_en = 1'b1; rd_addr = cur_ff; state_in = S_AF_N;
         end
         S_AF_N: begin
            lnk_n_in = rw2;
            wr_en = 1'b1; wr_addr = aux_ff; wr_word = ffha_pkg::W_NEXT; wr_data = rw2;
            state_in = S_AF_NL;
         end
         S_AF_NL: begin
            if (lnk_n_ff != '0) begin
               wr_en = 1'b1; wr_addr = lnk_n_ff; wr_word = ffha_pkg::W_PREV; wr_data = aux_ff;
            end
            state_in = S_AF_HDR;
         end
         S_AF_HDR: begin
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_SIZE;
            wr_data = amnt_ff - ffha_pkg::GRAN_B;
            state_in = S_AF_ST;
         end
         S_AF_ST: begin
            h_alloc = 1'b1; h_addr = cur_ff; h_size = amnt_ff - ffha_pkg::GRAN_B;
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_SANE; wr_data = h_out;
            addr_in = ffha_pkg::ADDR_W'(cur_ff + ffha_pkg::GRAN_B);
            state_in = S_DONE;
         end
         S_F_CHK: begin
            h_alloc = 1'b1; h_addr = cur_ff; h_size = rw0;
            if (rw3 != h_out) begin
               stat_in  = ffha_pkg::ST_SANITY;
               state_in = S_DONE;
            end else begin
               state_in = S_F_C1;
            end
         end
         S_F_C1: begin
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_PREV; wr_data = '0;
            state_in = S_F_C2;
         end
         S_F_C2: begin
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_NEXT; wr_data = '0;
            state_in = S_F_RD1;
         end
         S_F_RD1: begin
            rd_en = 1'b1; rd_addr = cur_ff; state_in = S_F_AFT;
         end
         S_F_AFT: begin
            aux_in = ptr_ff + rw0;
            rd_en = 1'b1; rd_addr = ptr_ff + rw0; state_in = S_F_CHKA;
         end
         S_F_CHKA: begin
            h_addr = aux_ff; h_size = rw0;
            if (rw3 == h_out) begin
               m_first_in = cur_ff; m_second_in = aux_ff; ret_in = S_F_RDP;
               state_in = S_M_RD;
            end else begin
               state_in = S_F_RDP;
            end
         end
         S_F_RDP: begin
            aux_in = cur_ff - ffha_pkg::GRAN_B;
            rd_en = 1'b1; rd_addr = cur_ff - ffha_pkg::GRAN_B; state_in = S_F_CHKP;
         end
         S_F_CHKP: begin
            h_addr = aux_ff; h_size = rw0;
            if (rw3 == h_out) begin
               m_first_in = aux_ff - rw0; m_second_in = cur_ff; ret_in = S_DONE;
               state_in = S_M_RD;
            end else begin
               state_in = S_F_P1;
            end
         end
         S_F_P1: begin
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_PREV; wr_data = '0;
            state_in = S_F_P2;
         end
         S_F_P2: begin
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_NEXT; wr_data = head_ff;
            state_in = S_F_P3;
         end
         S_F_P3: begin
            if (head_ff != '0) begin
               wr_en = 1'b1; wr_addr = head_ff; wr_word = ffha_pkg::W_PREV; wr_data = cur_ff;
            end
            state_in = S_F_RD2;
         end
         S_F_RD2: begin
            rd_en = 1'b1; rd_addr = cur_ff; state_in = S_F_ST;
         end
         S_F_ST: begin
            h_addr = cur_ff; h_size = rw0;
            wr_en = 1'b1; wr_addr = cur_ff; wr_word = ffha_pkg::W_SANE; wr_data = h_out;
            head_in = cur_ff; pf_hdr_in = cur_ff; ret_in = S_DONE;
            state_in = S_PF_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         granule_mem_ff[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         granule_mem_ff[ffha_pkg::slot_f(wr_addr)][{wr_word, 5'b0} +: WW] <= wr_data;
      end
      if (rd_en) begin
         mem_rdata_ff <= granule_mem_ff[ffha_pkg::slot_f(rd_addr)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         head_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         clearing_ff    <= 1'b1;
         clr_idx_ff     <= '0;
         arena_start_ff <= ffha_pkg::RST_ARENA_START;
         hole_start_ff  <= ffha_pkg::RST_HOLE_START;
         hole_end_ff    <= ffha_pkg::RST_HOLE_END;
         arena_end_ff   <= ffha_pkg::RST_ARENA_END;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         clearing_ff  <= clearing_in;
         clr_idx_ff   <= clr_idx_in;
         if (csr_we) begin
            unique case (csr_index)
               ffha_pkg::REG_ARENA_START: arena_start_ff <= csr_wdata;
               ffha_pkg::REG_HOLE_START:  hole_start_ff  <= csr_wdata;
               ffha_pkg::REG_HOLE_END:    hole_end_ff    <= csr_wdata;
               ffha_pkg::REG_ARENA_END:   arena_end_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;           cur_ff <= cur_in;           aux_ff <= aux_in;
      sz_ff <= sz_in;             lnk_p_ff <= lnk_p_in;       lnk_n_ff <= lnk_n_in;
      m_first_ff <= m_first_in;   m_second_ff <= m_second_in;
      pf_hdr_ff <= pf_hdr_in;     pf_ft_ff <= pf_ft_in;       pf_sz_ff <= pf_sz_in;
      tmp_ff <= tmp_in;           amnt_ff <= amnt_in;         ptr_ff <= ptr_in;
      steps_ff <= steps_in;       stat_ff <= stat_in;         addr_ff <= addr_in;
      rsp_addr_ff <= rsp_addr_in; rsp_status_ff <= rsp_status_in;
   end

endmodule
